/* hdl/rgb_led_pulse_encoder_macros.svh */
// assertion helpers shared by the encoder files
`ifndef RGB_LED_PULSE_ENCODER_MACROS_SVH
`define RGB_LED_PULSE_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RLPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlpe same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define RLPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlpe next-cycle check failed");

`endif

/* hdl/rlpe_pkg.sv */
package rlpe_pkg;

  localparam int BITS_PER_PIXEL   = 24;
  localparam int PULSE_BITS_DEF   = 16;
  localparam int FIELD_W          = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int SLOT_W           = $clog2(BITS_PER_PIXEL + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 2'd2;

  localparam logic [FIELD_W-1:0] ONE_WIDTH_RST  = 16'd66;
  localparam logic [FIELD_W-1:0] ZERO_WIDTH_RST = 16'd23;

  // floor(p / 100) = (p * 83887) >> 23 for every 16-bit p
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BITS_PER_PIXEL - 1);
  localparam logic [SLOT_W-1:0] GAP_SLOT  = SLOT_W'(BITS_PER_PIXEL);

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      frame_end;
  } pixel_t;

  typedef logic [255:0][7:0] gamma_tab_t;

  // round(255 * (i/255)^(20/9)), halves up, in exact integer arithmetic:
  // n steps past k while (2k+1)^9 * 255^11 <= 2^9 * i^20
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t   tab;
    logic [191:0] base;
    logic [191:0] rhs;
    logic [191:0] lhs;
    int           n;
    logic         done;
    base = 192'd1;
    for (int j = 0; j < 11; j++) base = base * 192'd255;
    n = 0;
    for (int i = 0; i < 256; i++) begin
      rhs = 192'd512;
      for (int j = 0; j < 20; j++) rhs = rhs * 192'(i);
      done = 1'b0;
      for (int s = 0; s < 255; s++) begin
        if (!done && n < 255) begin
          lhs = base;
          for (int j = 0; j < 9; j++) lhs = lhs * 192'(2 * n + 1);
          if (lhs <= rhs) n++;
          else done = 1'b1;
        end
      end
      tab[i] = 8'(n);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

/* hdl/rlpe_pixel_pipe.sv */
module rlpe_pixel_pipe
  import rlpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [23:0]  color,
  input  logic [7:0]   brightness,
  input  logic         frame_end,
  output logic         out_valid,
  input  logic         out_stall,
  output pixel_t       out_pixel
);

  // channel index: 0 blue, 1 green, 2 red
  logic        v1, v2, v3;
  logic [15:0] prod [3];
  logic [7:0]  lvl  [3];
  logic        fe1, fe2;
  pixel_t      pix3;

  logic ready1, ready2, ready3;
  logic [7:0] lvl_next [3];

  assign ready3   = !v3 || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // divide by 100 through the reciprocal, then clamp to full scale
  always_comb begin
    logic [32:0] q_full;
    for (int c = 0; c < 3; c++) begin
      q_full = 33'(prod[c]) * 33'(DIV100_MUL);
      if (q_full[32:DIV100_SHIFT] > 10'd255) lvl_next[c] = 8'hff;
      else lvl_next[c] = q_full[DIV100_SHIFT+7:DIV100_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      for (int c = 0; c < 3; c++) prod[c] <= 16'(color[8*c +: 8]) * 16'(brightness);
      fe1 <= frame_end;
    end
    if (ready2) begin
      for (int c = 0; c < 3; c++) lvl[c] <= lvl_next[c];
      fe2 <= fe1;
    end
    if (ready3) begin
      pix3.grb       <= {GAMMA_TAB[lvl[1]], GAMMA_TAB[lvl[2]], GAMMA_TAB[lvl[0]]};
      pix3.frame_end <= fe2;
    end
  end

  assign out_valid = v3;
  assign out_pixel = pix3;

endmodule

/* hdl/rgb_led_pulse_encoder.sv */
// Pulse encoder for a serial RGB LED chain. Each input word is one pixel: a
// packed red/green/blue color, a brightness in percent (a scaled level
// above full scale saturates) and a frame-end flag. Every channel is
// scaled, gamma corrected and sent in green, red, blue order, msb first,
// as 24 output words carrying the one or zero compare width; a frame-end
// pixel adds a 25th word with reset_gap set and pulse_width zero. last
// marks the final word of each pixel. Rate: one output word per cycle
// while out_stall is low, set by the bit serializer, which loads the next
// pixel in the same cycle that the last word of the current one is taken.
// An input pixel passes three scaling stages and the serializer load
// before its first word. Registers are written through cfg_write/cfg_index/
// cfg_data: 0 one width, 1 zero width, 2 reset slots (the gap length is
// timed by the line driver and does not enter any word); write only while
// the block is idle.
`include "rgb_led_pulse_encoder_macros.svh"

module rgb_led_pulse_encoder
  import rlpe_pkg::*;
#(
  parameter int PULSE_BITS = PULSE_BITS_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [23:0]          color,
  input  logic [7:0]           brightness,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   pulse_width,
  output logic                 reset_gap,
  output logic                 last
);

  // widths beyond the timer size are masked off at the write
  localparam int PW = (PULSE_BITS < FIELD_W) ? PULSE_BITS : FIELD_W;

  logic [PW-1:0] one_width;
  logic [PW-1:0] zero_width;

  // scaling and gamma pipeline
  logic   pix_valid;
  logic   pix_stall;
  pixel_t pix;

  // bit serializer state
  logic                      busy;
  logic [SLOT_W-1:0]         slot;
  logic [BITS_PER_PIXEL-1:0] shreg;
  logic                      fend;

  logic out_accept;
  logic take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      one_width  <= ONE_WIDTH_RST[PW-1:0];
      zero_width <= ZERO_WIDTH_RST[PW-1:0];
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ONE_WIDTH:   one_width  <= cfg_data[PW-1:0];
        REG_ZERO_WIDTH:  zero_width <= cfg_data[PW-1:0];
        REG_RESET_SLOTS: ;  // gap length is not part of any word
        default: ;          // unknown index, ignored
      endcase
    end
  end

  rlpe_pixel_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .color     (color),
    .brightness(brightness),
    .frame_end (frame_end),
    .out_valid (pix_valid),
    .out_stall (pix_stall),
    .out_pixel (pix)
  );

  // final word of the pixel: gap slot, or last bit slot with no gap to follow
  assign last       = (slot == GAP_SLOT) || (slot == LAST_SLOT && !fend);
  assign reset_gap  = (slot == GAP_SLOT);
  assign out_valid  = busy;
  assign out_accept = busy && !out_stall;

  // load the next pixel when empty or while the final word leaves
  assign take      = !busy || (out_accept && last);
  assign pix_stall = !take;

  always_comb begin
    if (reset_gap) pulse_width = '0;
    else if (shreg[BITS_PER_PIXEL-1]) pulse_width = FIELD_W'(one_width);
    else pulse_width = FIELD_W'(zero_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (take) begin
      busy <= pix_valid;
      slot <= '0;
    end else if (out_accept) begin
      slot <= slot + 1'b1;
    end
  end

  // msb-first shift, one bit slot per accepted word
  always_ff @(posedge clk) begin
    if (take) begin
      shreg <= pix.grb;
      fend  <= pix.frame_end;
    end else if (out_accept) begin
      shreg <= {shreg[BITS_PER_PIXEL-2:0], 1'b0};
    end
  end

  // gap word only after a frame-end pixel, and always final with zero width
  `RLPE_ASSERT_NOW(a_gap_word, out_valid && reset_gap, last && fend && pulse_width == '0)
  // slot counter stays within the bit slots and the gap slot
  `RLPE_ASSERT_NOW(a_slot_range, busy, slot <= GAP_SLOT)
  // a waiting pixel follows its predecessor's final word with no bubble
  `RLPE_ASSERT_NEXT(a_reload, out_accept && last && pix_valid, out_valid && slot == '0)
  // a stalled word keeps its slot
  `RLPE_ASSERT_NEXT(a_slot_hold, busy && out_stall, slot == $past(slot))

endmodule

/* tb/rgb_led_pulse_encoder_test.sv */
module rgb_led_pulse_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpe_pkg::*;

  // compare width of the block as instantiated (default parameter)
  localparam int PULSE_BITS = PULSE_BITS_DEF;

  // index with no register behind it, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // latch gap length after reset, tracked only, it never shows in a word
  localparam logic [FIELD_W-1:0] GAP_SLOTS_RST = 16'd300;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 55;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int IDLE_PERCENT     = 20;

  // one output word as the block should present it
  typedef struct packed {
    logic [FIELD_W-1:0] pulse_width;
    logic               reset_gap;
    logic               last;
  } led_word_t;

  class led_word_scoreboard;
    led_word_t          expected_words[$];
    logic [7:0]         gamma_curve[256];
    logic [FIELD_W-1:0] one_w;
    logic [FIELD_W-1:0] zero_w;
    logic [FIELD_W-1:0] gap_slots;
    int                 errors;

    function new();
      one_w     = ONE_WIDTH_RST;
      zero_w    = ZERO_WIDTH_RST;
      gap_slots = GAP_SLOTS_RST;
      errors    = 0;
      build_gamma_curve();
    endfunction

    // round(255 * (i/255)^(20/9)) with halves up: step n past k while
    // (2k+1)^9 * 255^11 <= 512 * i^20, n never goes down as i grows
    function void build_gamma_curve();
      logic [191:0] base;
      logic [191:0] rhs;
      logic [191:0] lhs;
      int           n;
      bit           stepping;
      base = 192'd1;
      for (int j = 0; j < 11; j++) base = base * 192'd255;
      n = 0;
      for (int i = 0; i < 256; i++) begin
        rhs = 192'd512;
        for (int j = 0; j < 20; j++) rhs = rhs * 192'(i);
        stepping = 1'b1;
        while (stepping && n < 255) begin
          lhs = base;
          for (int j = 0; j < 9; j++) lhs = lhs * 192'(2 * n + 1);
          if (lhs <= rhs) n++;
          else stepping = 1'b0;
        end
        gamma_curve[i] = 8'(n);
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      case (idx)
        REG_ONE_WIDTH:   one_w = data;
        REG_ZERO_WIDTH:  zero_w = data;
        REG_RESET_SLOTS: gap_slots = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] corrected(logic [7:0] chan, logic [7:0] pct);
      int unsigned v;
      v = (32'(chan) * 32'(pct)) / 100;
      if (v > 255) v = 255;
      return gamma_curve[v];
    endfunction

    function void note_pixel(logic [23:0] rgb, logic [7:0] pct, logic fend);
      logic [23:0]        grb;
      logic [FIELD_W-1:0] pmask;
      led_word_t          w;
      pmask = FIELD_W'((64'd1 << PULSE_BITS) - 64'd1);
      grb = {corrected(rgb[15:8], pct), corrected(rgb[23:16], pct),
             corrected(rgb[7:0], pct)};
      for (int k = 0; k < BITS_PER_PIXEL; k++) begin
        w.pulse_width = (grb[BITS_PER_PIXEL-1-k] ? one_w : zero_w) & pmask;
        w.reset_gap   = 1'b0;
        w.last        = !fend && (k == BITS_PER_PIXEL - 1);
        expected_words.push_back(w);
      end
      if (fend) begin
        w.pulse_width = '0;
        w.reset_gap   = 1'b1;
        w.last        = 1'b1;
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic [FIELD_W-1:0] pw, logic rg, logic lst);
      led_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: pulse_width %0d reset_gap %0b last %0b", pw, rg, lst);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (pw !== want.pulse_width) begin
        $error("pulse_width: expected %0d, got %0d", want.pulse_width, pw);
        errors++;
      end
      if (rg !== want.reset_gap) begin
        $error("reset_gap: expected %0b, got %0b", want.reset_gap, rg);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [FIELD_W-1:0]   cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [23:0]          color      = '0;
  logic [7:0]           brightness = '0;
  logic                 frame_end  = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [FIELD_W-1:0]   pulse_width;
  logic                 reset_gap;
  logic                 last;

  led_word_scoreboard sb;

  // quiet: no idling on either side for a whole phase
  bit quiet         = 1'b0;
  // hold-off requests from the main sequence, served by the stall process
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  rgb_led_pulse_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .color       (color),
    .brightness  (brightness),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pulse_width (pulse_width),
    .reset_gap   (reset_gap),
    .last        (last)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver side: random stall, none in quiet phases, and a long
  // hold-off counted here so the pipeline backs up into in_stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_OFF_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // every word taken at this edge goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_word(pulse_width, reset_gap, last);
  end

  // register write, only called while nothing is in flight
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_register(idx, data);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // offer one pixel word and hold it until the block takes it;
  // called at a rising edge, leaves in_valid high for the next call
  task automatic send_pixel(logic [23:0] c, logic [7:0] b, logic f);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    color      <= c;
    brightness <= b;
    frame_end  <= f;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(c, b, f);
  endtask

  // stop offering and wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  // random pixel: brightness mostly in range, some saturating, some extremes
  function automatic void random_pixel(output logic [23:0] c, output logic [7:0] b,
                                       output logic f);
    case ($urandom_range(9))
      0:       c = 24'h000000;
      1:       c = 24'hFFFFFF;
      2:       c = 24'hFF << (8 * $urandom_range(2));
      default: c = 24'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: b = 8'($urandom_range(100));
      5:             b = 8'd100;
      6, 7:          b = 8'($urandom_range(255, 101));
      8:             b = $urandom_range(1) ? 8'd255 : 8'd0;
      default:       b = 8'($urandom);
    endcase
    f = ($urandom_range(3) == 0);
  endfunction

  // short directed run at reset register values
  task automatic directed_pixels();
    send_pixel(24'h000000, 8'd100, 1'b0);
    send_pixel(24'hFFFFFF, 8'd100, 1'b0);
    // brightness above full scale clamps before the gamma lookup
    send_pixel(24'hFFFFFF, 8'd255, 1'b1);
    send_pixel(24'h000000, 8'd255, 1'b0);
    send_pixel(24'hFFFFFF, 8'd0,   1'b1);
    // one channel at a time shows the green, red, blue order
    send_pixel(24'hFF0000, 8'd100, 1'b0);
    send_pixel(24'h00FF00, 8'd100, 1'b0);
    send_pixel(24'h0000FF, 8'd100, 1'b1);
    send_pixel(24'h808080, 8'd101, 1'b0);
    send_pixel(24'h010101, 8'd200, 1'b0);
    send_pixel(24'h7F7F7F, 8'd100, 1'b0);
    send_pixel(24'hAA55AA, 8'd50,  1'b1);
    send_pixel(24'h55AA55, 8'd99,  1'b0);
    send_pixel(24'hFEFEFE, 8'd102, 1'b1);
    send_pixel(24'h123456, 8'd1,   1'b0);
    send_pixel(24'hABCDEF, 8'd150, 1'b1);
    send_pixel(24'h030201, 8'd128, 1'b1);
    send_pixel(24'hFFFFFF, 8'd254, 1'b0);
  endtask

  initial begin
    logic [23:0] c;
    logic [7:0]  b;
    logic        f;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_pixels();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          // widest one, narrowest zero, zero-length latch gap
          write_register(REG_ONE_WIDTH, 16'hFFFF);
          write_register(REG_ZERO_WIDTH, 16'h0000);
          write_register(REG_RESET_SLOTS, 16'h0000);
        end
        1: begin
          write_register(REG_ONE_WIDTH, 16'h0000);
          write_register(REG_ZERO_WIDTH, 16'hFFFF);
          write_register(REG_RESET_SLOTS, 16'hFFFF);
        end
        2: begin
          // random values, a dropped write, and no idling anywhere
          write_register(REG_ONE_WIDTH, 16'($urandom));
          write_register(REG_ZERO_WIDTH, 16'($urandom));
          write_register(REG_RESET_SLOTS, 16'($urandom));
          write_register(REG_UNUSED, 16'($urandom));
          quiet = 1'b1;
        end
        3: begin
          // long receiver hold-off while pixels keep coming
          write_register(REG_ONE_WIDTH, ONE_WIDTH_RST);
          write_register(REG_ZERO_WIDTH, ZERO_WIDTH_RST);
          hold_requests = hold_requests + 1;
        end
        4: begin
          write_register(REG_ONE_WIDTH, 16'h0001);
          write_register(REG_ZERO_WIDTH, 16'hFFFE);
          write_register(REG_RESET_SLOTS, 16'h0001);
        end
        default: begin
          write_register(REG_ONE_WIDTH, 16'($urandom));
          write_register(REG_ZERO_WIDTH, 16'($urandom));
          write_register(REG_RESET_SLOTS, GAP_SLOTS_RST);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_pixel(c, b, f);
        send_pixel(c, b, f);
      end
      drain();
      quiet = 1'b0;
    end

    // pipeline is four deep, give it a margin before the verdict
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("rgb_led_pulse_encoder_test: PASS");
    else
      $display("rgb_led_pulse_encoder_test: FAIL");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("rgb_led_pulse_encoder_test: FAIL");
    $finish;
  end

endmodule
